>>> rtl/core/pme_pkg.sv
// Shared constants and record types for the Euclidean spanning tree block.
`timescale 1ns / 1ps
package pme_pkg;
   localparam int MAX_CITIES_DEF = 64;
   localparam int COORD_W        = 15;
   localparam int IDX_W          = 6;
   localparam int KEY_W          = 17;
   localparam int CNT_W          = 7;
   localparam int WEIGHT_W       = 16;
   localparam int ROOT_W         = 32;
   localparam int ROOT_STEPS     = 16;
   localparam int FRONT_D        = 3;
   localparam logic [KEY_W-1:0] KEY_INF = '1;

   typedef struct packed {
      logic               valid;
      logic [IDX_W-1:0]   idx;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [KEY_W-1:0]   key;
      logic               in_tree;
      logic [IDX_W-1:0]   parent;
   } rec_type;

   typedef struct packed {
      rec_type            rec;
      logic               is_pick;
      logic [ROOT_W-1:0]  v;
      logic [ROOT_W-1:0]  res;
   } root_type;
endpackage

>>> rtl/core/prim_mst_euclidean.sv
// Top level: city ring with distance pipeline, dense Prim spanning tree.
// Loading: one city item accepted per cycle.
// After the last item, n-1 revolutions of the city ring through its
// 19-stage distance and square-root pipeline, then n results,
// one per cycle while rsp_stall is low.
// Synchronous active-high reset empties the city set and the pipeline.
`timescale 1ns / 1ps
module prim_mst_euclidean #(
   parameter int MAX_CITIES = pme_pkg::MAX_CITIES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [pme_pkg::COORD_W-1:0]  req_coord_x,
   input  logic [pme_pkg::COORD_W-1:0]  req_coord_y,
   input  logic                         req_last_city,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [pme_pkg::IDX_W-1:0]    rsp_vertex,
   output logic [pme_pkg::IDX_W-1:0]    rsp_parent_vertex,
   output logic [pme_pkg::WEIGHT_W-1:0] rsp_edge_weight,
   output logic                         rsp_has_parent,
   output logic                         rsp_last_result
);
   import pme_pkg::*;

   localparam int PIPE_D   = FRONT_D + ROOT_STEPS;
   localparam int RING_LEN = MAX_CITIES + PIPE_D;
   localparam int REV_W    = $clog2(RING_LEN);

   localparam logic [1:0] ST_LOAD = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   iter_ff, iter_in;
   logic [REV_W-1:0]   rev_ff, rev_in;
   logic [IDX_W-1:0]   pick_ff, pick_in;
   logic [COORD_W-1:0] pick_x_ff, pick_x_in, pick_y_ff, pick_y_in;
   logic               found_ff, found_in;
   logic [KEY_W-1:0]   bkey_ff, bkey_in;
   logic [IDX_W-1:0]   bidx_ff, bidx_in;
   logic [COORD_W-1:0] bx_ff, bx_in, by_ff, by_in;

   rec_type cell_q [MAX_CITIES];
   rec_type cell_d [MAX_CITIES];
   rec_type new_rec;
   rec_type upd_rec;

   logic req_acc, rsp_acc, run, shift_en, clear, rev_end, cand, better, last_out;
   logic [CNT_W-1:0] n_cities;
   logic [KEY_W-1:0] rdist;

   rec_type                f1_rec_ff, f2_rec_ff;
   logic                   f1_pick_ff, f2_pick_ff;
   logic [COORD_W-1:0]     f1_dx_ff, f1_dy_ff, dx_in, dy_in;
   logic [2*COORD_W-1:0]   f2_sx_ff, f2_sy_ff;
   root_type               root_q [ROOT_STEPS+1];
   root_type               f3_in;

   assign req_acc  = req_valid && !req_stall;
   assign rsp_acc  = rsp_valid && !rsp_stall;
   assign run      = (state_ff == ST_RUN);
   assign shift_en = run || rsp_acc;
   assign last_out = ({1'b0, cell_q[0].idx} == count_ff - CNT_W'(1));
   assign clear    = rsp_acc && last_out;
   assign rev_end  = run && (rev_ff == REV_W'(RING_LEN - 1));

   always_comb begin
      new_rec         = '0;
      new_rec.valid   = 1'b1;
      new_rec.idx     = count_ff[IDX_W-1:0];
      new_rec.x       = req_coord_x;
      new_rec.y       = req_coord_y;
      new_rec.key     = KEY_INF;
   end

   for (genvar i = 0; i < MAX_CITIES; i++) begin : g_cell
      if (i < MAX_CITIES - 1) begin : g_mid
         assign cell_d[i] = cell_q[i+1];
      end else begin : g_tail
         assign cell_d[i] = run ? upd_rec : cell_q[0];
      end
      pme_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (shift_en),
         .write_en  (req_acc && (count_ff == CNT_W'(i))),
         .clear     (clear),
         .write_rec (new_rec),
         .next_rec  (cell_d[i]),
         .rec       (cell_q[i])
      );
   end

   // distance front end
   always_comb begin
      dx_in = (cell_q[0].x > pick_x_ff) ? cell_q[0].x - pick_x_ff : pick_x_ff - cell_q[0].x;
      dy_in = (cell_q[0].y > pick_y_ff) ? cell_q[0].y - pick_y_ff : pick_y_ff - cell_q[0].y;
      f3_in         = '0;
      f3_in.rec     = f2_rec_ff;
      f3_in.is_pick = f2_pick_ff;
      f3_in.v       = ROOT_W'(f2_sx_ff) + ROOT_W'(f2_sy_ff);
   end

   always_ff @(posedge clock) begin
      if (run) begin
         f1_rec_ff  <= cell_q[0];
         f1_pick_ff <= (cell_q[0].idx == pick_ff);
         f1_dx_ff   <= dx_in;
         f1_dy_ff   <= dy_in;
         f2_rec_ff  <= f1_rec_ff;
         f2_pick_ff <= f1_pick_ff;
         f2_sx_ff   <= f1_dx_ff * f1_dx_ff;
         f2_sy_ff   <= f1_dy_ff * f1_dy_ff;
         root_q[0]  <= f3_in;
      end
      if (reset) begin
         f1_rec_ff.valid     <= 1'b0;
         f2_rec_ff.valid     <= 1'b0;
         root_q[0].rec.valid <= 1'b0;
      end
   end

   for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
      pme_root_stage #(.STEP(k)) u_root (
         .clock (clock),
         .reset (reset),
         .en    (run),
         .din   (root_q[k]),
         .dout  (root_q[k+1])
      );
   end

   // rounding and key update
   always_comb begin
      rdist   = KEY_W'(root_q[ROOT_STEPS].res) +
                KEY_W'(root_q[ROOT_STEPS].v > root_q[ROOT_STEPS].res);
      upd_rec = root_q[ROOT_STEPS].rec;
      if (upd_rec.valid) begin
         if (root_q[ROOT_STEPS].is_pick) begin
            upd_rec.in_tree = 1'b1;
         end else if (!upd_rec.in_tree && rdist != '0 && rdist < upd_rec.key) begin
            upd_rec.key    = rdist;
            upd_rec.parent = pick_ff;
         end
      end
      cand   = upd_rec.valid && !upd_rec.in_tree;
      better = cand && (!found_ff || {upd_rec.key, upd_rec.idx} < {bkey_ff, bidx_ff});
   end

   assign n_cities = (count_ff < CNT_W'(MAX_CITIES)) ? count_ff + CNT_W'(1) : count_ff;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      iter_in   = iter_ff;
      rev_in    = rev_ff;
      pick_in   = pick_ff;
      pick_x_in = pick_x_ff;
      pick_y_in = pick_y_ff;
      found_in  = found_ff;
      bkey_in   = bkey_ff;
      bidx_in   = bidx_ff;
      bx_in     = bx_ff;
      by_in     = by_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_acc) begin
               count_in = n_cities;
               if (req_last_city) begin
                  if (n_cities == CNT_W'(1)) begin
                     state_in = ST_OUT;
                  end else begin
                     state_in  = ST_RUN;
                     iter_in   = n_cities - CNT_W'(1);
                     rev_in    = '0;
                     pick_in   = '0;
                     pick_x_in = cell_q[0].x;
                     pick_y_in = cell_q[0].y;
                     found_in  = 1'b0;
                  end
               end
            end
         end
         ST_RUN: begin
            rev_in = rev_ff + REV_W'(1);
            if (better) begin
               found_in = 1'b1;
               bkey_in  = upd_rec.key;
               bidx_in  = upd_rec.idx;
               bx_in    = upd_rec.x;
               by_in    = upd_rec.y;
            end
            if (rev_end) begin
               rev_in    = '0;
               found_in  = 1'b0;
               iter_in   = iter_ff - CNT_W'(1);
               pick_in   = better ? upd_rec.idx : bidx_ff;
               pick_x_in = better ? upd_rec.x : bx_ff;
               pick_y_in = better ? upd_rec.y : by_ff;
               if (iter_ff == CNT_W'(1)) begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            if (clear) begin
               state_in = ST_LOAD;
               count_in = '0;
            end
         end
         default: begin
            state_in = ST_LOAD;
            count_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         iter_ff  <= '0;
         rev_ff   <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         iter_ff  <= iter_in;
         rev_ff   <= rev_in;
         found_ff <= found_in;
      end
      pick_ff   <= pick_in;
      pick_x_ff <= pick_x_in;
      pick_y_ff <= pick_y_in;
      bkey_ff   <= bkey_in;
      bidx_ff   <= bidx_in;
      bx_ff     <= bx_in;
      by_ff     <= by_in;
   end

   assign req_stall         = (state_ff != ST_LOAD);
   assign rsp_valid         = (state_ff == ST_OUT);
   assign rsp_has_parent    = (cell_q[0].idx != '0) && (cell_q[0].key != KEY_INF);
   assign rsp_vertex        = cell_q[0].idx;
   assign rsp_parent_vertex = rsp_has_parent ? cell_q[0].parent : '0;
   assign rsp_edge_weight   = rsp_has_parent ? cell_q[0].key[WEIGHT_W-1:0] : '0;
   assign rsp_last_result   = last_out;

`ifndef SYNTHESIS
   a_pipe_empty_at_start: assert property (@(posedge clock) disable iff (reset)
      (run && rev_ff == '0) |-> !root_q[ROOT_STEPS].rec.valid)
      else $error("distance pipeline not empty at revolution start");
   a_out_record: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (cell_q[0].valid && ({1'b0, cell_q[0].idx} < count_ff)))
      else $error("result taken from an absent city");
   a_pick_found: assert property (@(posedge clock) disable iff (reset)
      (rev_end && iter_ff > CNT_W'(1)) |-> (found_ff || cand))
      else $error("no unvisited city found for next pick");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_CITIES))
      else $error("city count beyond capacity");
`endif
endmodule

>>> rtl/core/pme_cell.sv
// Ring cell holding one city record.
`timescale 1ns / 1ps
module pme_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             shift_en,
   input  logic             write_en,
   input  logic             clear,
   input  pme_pkg::rec_type write_rec,
   input  pme_pkg::rec_type next_rec,
   output pme_pkg::rec_type rec
);
   import pme_pkg::*;

   rec_type rec_ff;
   rec_type rec_in;

   always_comb begin
      rec_in = rec_ff;
      if (write_en) begin
         rec_in = write_rec;
      end else if (shift_en) begin
         rec_in = next_rec;
      end
      if (clear) begin
         rec_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
      if (reset) begin
         rec_ff.valid <= 1'b0;
      end
   end

   assign rec = rec_ff;
endmodule

>>> rtl/core/pme_root_stage.sv
// One digit step of the pipelined integer square root.
`timescale 1ns / 1ps
module pme_root_stage #(
   parameter int STEP = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  pme_pkg::root_type din,
   output pme_pkg::root_type dout
);
   import pme_pkg::*;

   localparam logic [ROOT_W-1:0] BIT = ROOT_W'(1) << (ROOT_W - 2 - 2 * STEP);

   root_type out_ff;
   root_type out_in;
   logic [ROOT_W-1:0] trial;

   always_comb begin
      out_in = din;
      trial  = din.res + BIT;
      if (din.v >= trial) begin
         out_in.v   = din.v - trial;
         out_in.res = (din.res >> 1) + BIT;
      end else begin
         out_in.res = din.res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
      if (reset) begin
         out_ff.rec.valid <= 1'b0;
      end
   end

   assign dout = out_ff;
endmodule

>>> dv/pme_checker.sv
// Checker for the spanning tree block: watches both channels, predicts and compares.
`timescale 1ns / 1ps
module pme_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [pme_pkg::COORD_W-1:0]  req_coord_x,
   input  logic [pme_pkg::COORD_W-1:0]  req_coord_y,
   input  logic                         req_last_city,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [pme_pkg::IDX_W-1:0]    rsp_vertex,
   input  logic [pme_pkg::IDX_W-1:0]    rsp_parent_vertex,
   input  logic [pme_pkg::WEIGHT_W-1:0] rsp_edge_weight,
   input  logic                         rsp_has_parent,
   input  logic                         rsp_last_result,
   output int                           mismatches,
   output int                           outstanding
);
   import pme_pkg::*;

   localparam int NCITY = MAX_CITIES_DEF;

   typedef struct {
      logic [IDX_W-1:0]    vertex;
      logic [IDX_W-1:0]    parent;
      logic [WEIGHT_W-1:0] weight;
      logic                has;
      logic                last;
   } tree_row_type;

   tree_row_type        tree_q[$];
   logic [COORD_W-1:0]  city_x[NCITY];
   logic [COORD_W-1:0]  city_y[NCITY];
   int                  n_stored;

   function automatic logic [31:0] int_root(logic [31:0] v);
      logic [31:0] r;
      logic [31:0] b;
      r = '0;
      b = 32'h4000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [KEY_W-1:0] city_dist(int a, int b);
      logic [31:0] dx;
      logic [31:0] dy;
      logic [31:0] d2;
      logic [31:0] r;
      dx = 32'(city_x[a] > city_x[b] ? city_x[a] - city_x[b] : city_x[b] - city_x[a]);
      dy = 32'(city_y[a] > city_y[b] ? city_y[a] - city_y[b] : city_y[b] - city_y[a]);
      d2 = dx * dx + dy * dy;
      r  = int_root(d2);
      if (d2 > r * r + r) r = r + 32'd1;
      return r[KEY_W-1:0];
   endfunction

   task automatic build_tree();
      logic [KEY_W-1:0] key[NCITY];
      bit               joined[NCITY];
      logic [IDX_W-1:0] par[NCITY];
      logic [KEY_W-1:0] pk;
      logic [KEY_W-1:0] d;
      int               pick;
      tree_row_type     row;
      for (int i = 0; i < NCITY; i++) begin
         key[i] = KEY_INF;
         joined[i] = 1'b0;
         par[i] = '0;
      end
      key[0] = '0;
      for (int it = 0; it + 1 < n_stored; it++) begin
         pick = n_stored;
         pk = KEY_INF;
         for (int i = 0; i < n_stored; i++)
            if (!joined[i] && key[i] < pk) begin
               pk = key[i];
               pick = i;
            end
         if (pick == n_stored)
            for (int i = n_stored - 1; i >= 0; i--)
               if (!joined[i]) pick = i;
         if (pick >= n_stored) break;
         joined[pick] = 1'b1;
         for (int j = 0; j < n_stored; j++)
            if (!joined[j]) begin
               d = city_dist(pick, j);
               if (d != 0 && d < key[j]) begin
                  key[j] = d;
                  par[j] = pick[IDX_W-1:0];
               end
            end
      end
      for (int i = 0; i < n_stored; i++) begin
         row.vertex = i[IDX_W-1:0];
         row.has    = (i != 0) && (key[i] != KEY_INF);
         row.parent = row.has ? par[i] : '0;
         row.weight = row.has ? key[i][WEIGHT_W-1:0] : '0;
         row.last   = (i + 1 == n_stored);
         tree_q.insert(tree_q.size(), row);
      end
      n_stored = 0;
   endtask

   function automatic void report(string field, int unsigned exp_v, int unsigned act_v);
      $display("%0t mismatch %s: expected %0d actual %0d", $time, field, exp_v, act_v);
      mismatches++;
   endfunction

   initial begin
      mismatches  = 0;
      outstanding = 0;
      n_stored    = 0;
   end

   always @(posedge clock) begin
      tree_row_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (tree_q.size() == 0) begin
               $display("%0t unexpected item: expected none actual vertex %0d",
                        $time, rsp_vertex);
               mismatches++;
            end else begin
               e = tree_q.pop_front();
               if (rsp_vertex !== e.vertex)
                  report("vertex", 32'(e.vertex), 32'(rsp_vertex));
               if (rsp_parent_vertex !== e.parent)
                  report("parent_vertex", 32'(e.parent), 32'(rsp_parent_vertex));
               if (rsp_edge_weight !== e.weight)
                  report("edge_weight", 32'(e.weight), 32'(rsp_edge_weight));
               if (rsp_has_parent !== e.has)
                  report("has_parent", 32'(e.has), 32'(rsp_has_parent));
               if (rsp_last_result !== e.last)
                  report("last_result", 32'(e.last), 32'(rsp_last_result));
            end
         end
         if (req_valid && !req_stall) begin
            if (n_stored < NCITY) begin
               city_x[n_stored] = req_coord_x;
               city_y[n_stored] = req_coord_y;
               n_stored++;
            end
            if (req_last_city) build_tree();
         end
         outstanding = tree_q.size();
      end
   end
endmodule

>>> dv/tb.sv
// Testbench top: clock, reset, city stimulus, result stalls and the verdict.
`timescale 1ns / 1ps
module tb;
   import pme_pkg::*;

   localparam int TARGET = 410;
   localparam int LIMIT  = 1500000;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [COORD_W-1:0]  req_coord_x;
   logic [COORD_W-1:0]  req_coord_y;
   logic                req_last_city;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [IDX_W-1:0]    rsp_vertex;
   logic [IDX_W-1:0]    rsp_parent_vertex;
   logic [WEIGHT_W-1:0] rsp_edge_weight;
   logic                rsp_has_parent;
   logic                rsp_last_result;
   int                  mismatches;
   int                  outstanding;
   int                  sent;
   int                  got;
   bit                  calm;
   int                  cycles;

   prim_mst_euclidean i_dut (.*);

   pme_checker i_chk (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic send_city(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic last);
      req_valid     <= 1'b1;
      req_coord_x   <= x;
      req_coord_y   <= y;
      req_last_city <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // style: 0 full range, 1 tiny grid (duplicates, ties), 2 corners only
   task automatic send_set(int n, int style);
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      for (int i = 0; i < n; i++) begin
         case (style)
            1: begin
               x = COORD_W'($urandom_range(0, 3));
               y = COORD_W'($urandom_range(0, 3));
            end
            2: begin
               x = $urandom_range(0, 1) ? '1 : '0;
               y = $urandom_range(0, 1) ? '1 : '0;
            end
            default: begin
               x = COORD_W'($urandom);
               y = COORD_W'($urandom);
            end
         endcase
         send_city(x, y, i == n - 1);
      end
   endtask

   // result side: random short stalls, one long hold-off
   initial begin
      bit held;
      held = 1'b0;
      got = 0;
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) got++;
         if (!held && got >= 30) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (600) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 3) - 1) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      int n;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_coord_x   = '0;
      req_coord_y   = '0;
      req_last_city = 1'b0;
      sent          = 0;
      calm          = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single city
      send_city('1, '1, 1'b1);
      // extremes, far apart
      send_city('0, '0, 1'b0);
      send_city('1, '1, 1'b1);
      // coincident pair: second city unreachable
      send_city(15'd100, 15'd200, 1'b0);
      send_city(15'd100, 15'd200, 1'b1);
      // ties on a square, plus a duplicate of the root
      send_city(15'd0, 15'd0, 1'b0);
      send_city(15'd0, 15'd10, 1'b0);
      send_city(15'd10, 15'd0, 1'b0);
      send_city(15'd10, 15'd10, 1'b0);
      send_city(15'd0, 15'd0, 1'b0);
      send_city(15'h5555, 15'h2AAA, 1'b1);
      // rounding: distances sqrt(2), sqrt(5), sqrt(13)
      send_city(15'd0, 15'd0, 1'b0);
      send_city(15'd1, 15'd1, 1'b0);
      send_city(15'd2, 15'd3, 1'b0);
      send_city(15'h2AAA, 15'h5555, 1'b1);
      // corners with repeats
      send_set(8, 2);

      // too many cities: the extra items are dropped, the last still starts the run
      send_set(67, $urandom_range(0, 1));
      send_set(64, 0);

      while (sent < TARGET) begin
         if (sent > TARGET - 50) calm = 1'b1;
         n = ($urandom_range(0, 29) == 0) ? 64 : $urandom_range(1, 10);
         send_set(n, $urandom_range(0, 5) < 3 ? 0 : $urandom_range(1, 2));
      end
      // a few stray non-final items followed by a final one
      calm = 1'b1;
      send_set(3, 0);
      req_valid <= 1'b0;
      @(posedge clock);

      while (outstanding != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
